// File: design/bdpc_pkg.sv
// Package for the button debounce and press classifier.
// Holds the item, result, state and configuration types and the shared codes.
// No dependencies.
`default_nettype none

package bdpc_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_SAMPLE      = 2'd0;
  localparam logic [1:0] OP_QUERY_CLICK = 2'd1;
  localparam logic [1:0] OP_QUERY_HELD  = 2'd2;
  localparam logic [1:0] OP_QUERY_LONG  = 2'd3;

  // Event and press class codes.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CLICK = 2'd1;
  localparam logic [1:0] EV_HELD  = 2'd2;
  localparam logic [1:0] EV_LONG  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_INVERT_LEVEL  = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE_US   = 3'd1;
  localparam logic [2:0] REG_CLICK_US      = 3'd2;
  localparam logic [2:0] REG_HOLD_US       = 3'd3;
  localparam logic [2:0] REG_LONG_PRESS_US = 3'd4;

  localparam int unsigned ADDR_W = 5;

  // Configuration reset values.
  localparam logic [31:0] DEBOUNCE_US_RST   = 32'd10000;
  localparam logic [31:0] CLICK_US_RST      = 32'd50000;
  localparam logic [31:0] HOLD_US_RST       = 32'd1000000;
  localparam logic [31:0] LONG_PRESS_US_RST = 32'd3000000;

  typedef struct packed {
    logic [1:0]  op;
    logic        raw_level;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic       pressed;
    logic [1:0] pending_event;
    logic       query_hit;
  } result_t;

  typedef struct packed {
    logic        previous_level;
    logic        stable_level;
    logic [31:0] change_time;
    logic [1:0]  running_class;
    logic [1:0]  latched_event;
  } state_t;

  typedef struct packed {
    logic        invert_level;
    logic [31:0] debounce_us;
    logic [31:0] click_us;
    logic [31:0] hold_us;
    logic [31:0] long_press_us;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/bdpc_step.sv
// Next-state and result logic for one item of the button classifier.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_step (
  input  bdpc_pkg::state_t  state,
  input  bdpc_pkg::cfg_t    cfg,
  input  bdpc_pkg::item_t   item,
  output bdpc_pkg::state_t  state_next,
  output bdpc_pkg::result_t result_next
);

  logic        level;
  logic        level_changed;
  logic [31:0] change_time_new;
  logic [31:0] elapsed;
  logic        stable_new;

  assign level           = item.raw_level ^ cfg.invert_level;
  assign level_changed   = level != state.previous_level;
  assign change_time_new = level_changed ? item.now_us : state.change_time;
  assign elapsed         = item.now_us - change_time_new;

  always_comb begin
    state_next  = state;
    stable_new  = state.stable_level;
    result_next = '0;
    if (item.op == bdpc_pkg::OP_SAMPLE) begin
      state_next.change_time    = change_time_new;
      state_next.previous_level = level;
      if ((elapsed > cfg.debounce_us) && (level != state.stable_level)) begin
        stable_new               = level;
        state_next.latched_event = state.running_class;
      end
      state_next.stable_level = stable_new;
      // The class is set only while pressed; below the click threshold it keeps its old value.
      if (stable_new) begin
        if (elapsed > cfg.long_press_us) begin
          state_next.running_class = bdpc_pkg::EV_LONG;
        end else if (elapsed > cfg.hold_us) begin
          state_next.running_class = bdpc_pkg::EV_HELD;
        end else if (elapsed > cfg.click_us) begin
          state_next.running_class = bdpc_pkg::EV_CLICK;
        end
      end else begin
        state_next.running_class = bdpc_pkg::EV_NONE;
      end
    end else if (state.latched_event == item.op) begin
      result_next.query_hit    = 1'b1;
      state_next.latched_event = bdpc_pkg::EV_NONE;
    end
    result_next.pressed       = state_next.stable_level;
    result_next.pending_event = state_next.latched_event;
  end

endmodule

`default_nettype wire

// File: design/button_debounce_press_classifier.sv
// Results are registered; input takes one item per cycle while the skid register is empty.
// The state update for each item is a single registered pass (one subtract, four threshold compares).
// A two-entry result buffer (output register plus skid register) keeps input accepting
// while one result waits. Reset (rst, synchronous, active high) clears the debounce state
// and both result slots and loads the configuration registers with their default values.
// Top level of the button debounce and press classifier; depends on bdpc_pkg, bdpc_step.
`default_nettype none

module button_debounce_press_classifier (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdpc_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Item channel.
  input  logic                              item_valid,
  output logic                              item_ready,
  input  bdpc_pkg::item_t                   item,
  // Result channel.
  output logic                              result_valid,
  input  logic                              result_ready,
  output bdpc_pkg::result_t                 result
);

  // Configuration registers. Each register sits at byte address 4 * index.
  bdpc_pkg::cfg_t cfg;
  logic [2:0]     reg_index;
  logic           cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[bdpc_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_level  <= 1'b0;
      cfg.debounce_us   <= bdpc_pkg::DEBOUNCE_US_RST;
      cfg.click_us      <= bdpc_pkg::CLICK_US_RST;
      cfg.hold_us       <= bdpc_pkg::HOLD_US_RST;
      cfg.long_press_us <= bdpc_pkg::LONG_PRESS_US_RST;
    end else if (cfg_write) begin
      case (reg_index)
        bdpc_pkg::REG_INVERT_LEVEL:  cfg.invert_level  <= pwdata[0];
        bdpc_pkg::REG_DEBOUNCE_US:   cfg.debounce_us   <= pwdata;
        bdpc_pkg::REG_CLICK_US:      cfg.click_us      <= pwdata;
        bdpc_pkg::REG_HOLD_US:       cfg.hold_us       <= pwdata;
        bdpc_pkg::REG_LONG_PRESS_US: cfg.long_press_us <= pwdata;
        default: ;
      endcase
    end
  end

  // Reads of unmapped addresses return zero.
  always_comb begin
    case (reg_index)
      bdpc_pkg::REG_INVERT_LEVEL:  prdata = {31'd0, cfg.invert_level};
      bdpc_pkg::REG_DEBOUNCE_US:   prdata = cfg.debounce_us;
      bdpc_pkg::REG_CLICK_US:      prdata = cfg.click_us;
      bdpc_pkg::REG_HOLD_US:       prdata = cfg.hold_us;
      bdpc_pkg::REG_LONG_PRESS_US: prdata = cfg.long_press_us;
      default:                     prdata = '0;
    endcase
  end

  // Debounce and classification state. It is updated at every item transfer, so the
  // next item always sees the state left by the one before it.
  bdpc_pkg::state_t  state;
  bdpc_pkg::state_t  state_next;
  bdpc_pkg::result_t result_next;

  bdpc_step u_step (
    .state       (state),
    .cfg         (cfg),
    .item        (item),
    .state_next  (state_next),
    .result_next (result_next)
  );

  logic item_xfer;
  logic result_xfer;

  assign item_xfer   = item_valid && item_ready;
  assign result_xfer = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (item_xfer) begin
      state <= state_next;
    end
  end

  // Result buffer. The skid register catches a new result when the output register is
  // full and not being drained; input stalls only while the skid register is occupied.
  bdpc_pkg::result_t skid;
  logic              skid_valid;

  assign item_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (item_xfer) begin
      if (!result_valid || result_xfer) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (result_xfer) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      if (!result_valid || result_xfer) begin
        result <= result_next;
      end else begin
        skid <= result_next;
      end
    end else if (result_xfer && skid_valid) begin
      result <= skid;
    end
  end

  // The skid register is only ever filled behind a full output register.
  a_skid_behind_output : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register holds a result while the output register is empty");

  // A query that hits always clears the pending event it reports on.
  a_hit_clears_event : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.query_hit) |-> (result.pending_event == bdpc_pkg::EV_NONE))
    else $error("query hit left an event pending");

  // A query never moves the debounced state.
  a_query_keeps_state : assert property (@(posedge clk) disable iff (rst)
    (item_xfer && (item.op != bdpc_pkg::OP_SAMPLE)) |=>
      (state.stable_level == $past(state.stable_level)))
    else $error("query changed the debounced state");

  // A press class builds up only while the button reads as pressed.
  a_class_only_pressed : assert property (@(posedge clk) disable iff (rst)
    (state.running_class != bdpc_pkg::EV_NONE) |-> state.stable_level)
    else $error("press class set while released");

endmodule

`default_nettype wire

// File: tb/tb_button_debounce_press_classifier.sv
`timescale 1ns / 100ps
// Self-checking testbench for the button debounce and press classifier.
// Drives items and APB register writes, predicts every result in SystemVerilog.
// Depends on bdpc_pkg and button_debounce_press_classifier.

module tb_button_debounce_press_classifier;
  import bdpc_pkg::*;

  // Run limits.
  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          IDLE_PCT        = 23;
  localparam int          PHASES          = 6;
  localparam int          ITEMS_PER_PHASE = 300;
  localparam int          DRAIN_CYCLES    = 4;

  // Register indexes past the last defined one; writes there must be ignored.
  localparam logic [2:0]  REG_SPARE_LO    = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI    = 3'd7;

  // Marks whether a directed row carries a hand-written expectation.
  localparam logic        CHECK_TYPED     = 1'b1;
  localparam logic        CHECK_MODEL     = 1'b0;

  typedef struct packed {
    item_t   stim;
    logic    typed;
    result_t want;
  } row_t;

  localparam int N_DIRECTED = 26;

  // Directed walk with the reset configuration: debounce 10000, click 50000,
  // hold 1000000, long press 3000000. The first block is a full press that
  // climbs through every class and is released as a long press, then read
  // back by queries. The second block wraps the timestamp through zero,
  // latches a click, and shows that a new press clears the pending event.
  // The last rows end a held press and are checked against the predictor.
  localparam row_t DIRECTED [N_DIRECTED] = '{
    {OP_QUERY_CLICK, 1'b0, 32'h0000_0000, CHECK_TYPED, 1'b0, EV_NONE,  1'b0},
    {OP_QUERY_LONG,  1'b1, 32'hFFFF_FFFF, CHECK_TYPED, 1'b0, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b0, 32'd0,         CHECK_TYPED, 1'b0, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b1, 32'd100,       CHECK_TYPED, 1'b0, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b1, 32'd10100,     CHECK_TYPED, 1'b0, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b1, 32'd10101,     CHECK_TYPED, 1'b1, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b1, 32'd50100,     CHECK_TYPED, 1'b1, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b1, 32'd50101,     CHECK_TYPED, 1'b1, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b1, 32'd1000101,   CHECK_TYPED, 1'b1, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b1, 32'd3000101,   CHECK_TYPED, 1'b1, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b0, 32'd3000200,   CHECK_TYPED, 1'b1, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b0, 32'd3010201,   CHECK_TYPED, 1'b0, EV_LONG,  1'b0},
    {OP_QUERY_CLICK, 1'b0, 32'h0000_0000, CHECK_TYPED, 1'b0, EV_LONG,  1'b0},
    {OP_QUERY_HELD,  1'b1, 32'hFFFF_FFFF, CHECK_TYPED, 1'b0, EV_LONG,  1'b0},
    {OP_QUERY_LONG,  1'b0, 32'h0000_0000, CHECK_TYPED, 1'b0, EV_NONE,  1'b1},
    {OP_SAMPLE,      1'b1, 32'hFFFF_FF00, CHECK_TYPED, 1'b0, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b1, 32'h0000_2800, CHECK_TYPED, 1'b1, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b1, 32'h0000_C400, CHECK_TYPED, 1'b1, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b0, 32'h0000_C500, CHECK_TYPED, 1'b1, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b0, 32'h0000_EC11, CHECK_TYPED, 1'b0, EV_CLICK, 1'b0},
    {OP_SAMPLE,      1'b1, 32'hFFFF_FFFF, CHECK_TYPED, 1'b0, EV_CLICK, 1'b0},
    {OP_SAMPLE,      1'b1, 32'h0000_2710, CHECK_TYPED, 1'b1, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b1, 32'h000F_4B22, CHECK_MODEL, 1'b0, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b0, 32'h000F_4C00, CHECK_MODEL, 1'b0, EV_NONE,  1'b0},
    {OP_SAMPLE,      1'b0, 32'h000F_7311, CHECK_MODEL, 1'b0, EV_NONE,  1'b0},
    {OP_QUERY_HELD,  1'b0, 32'h0000_0000, CHECK_MODEL, 1'b0, EV_NONE,  1'b0}
  };

  // Every input starts at a known value; rst is held high from time zero.
  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [31:0]         pwdata       = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                item_valid   = 1'b0;
  logic                item_ready;
  item_t               item_data    = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  result_t             result_data;

  // Knobs shared between the stimulus process and the result receiver.
  bit                  gaps_on      = 1'b1;
  bit                  hold_off_req = 1'b0;

  // Predictor copy of the configuration and the debounce state.
  cfg_t                shadow_cfg;
  state_t              btn_state;

  // Results the block owes us, oldest first.
  result_t             due_results[$];
  int                  mismatch_count = 0;
  int                  cycle_count    = 0;

  button_debounce_press_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_data)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Predicts the result of one item and advances the predictor state.
  // A level change restarts the stability timer; once the level has been
  // stable for strictly longer than the debounce time, the debounced state
  // follows it and the class built so far becomes the pending event. While
  // pressed, the time since the last change picks the highest threshold it
  // exceeds; below the click threshold the class is left as it was.
  function automatic result_t debounce_step(input item_t it);
    result_t     res;
    logic        level;
    logic [31:0] elapsed;
    res = '0;
    if (it.op == OP_SAMPLE) begin
      level = it.raw_level ^ shadow_cfg.invert_level;
      if (level != btn_state.previous_level) begin
        btn_state.change_time = it.now_us;
      end
      // Unsigned 32-bit subtraction gives the wrap-safe difference.
      elapsed = it.now_us - btn_state.change_time;
      if (elapsed > shadow_cfg.debounce_us && level != btn_state.stable_level) begin
        btn_state.stable_level  = level;
        btn_state.latched_event = btn_state.running_class;
      end
      if (btn_state.stable_level) begin
        if (elapsed > shadow_cfg.long_press_us) begin
          btn_state.running_class = EV_LONG;
        end else if (elapsed > shadow_cfg.hold_us) begin
          btn_state.running_class = EV_HELD;
        end else if (elapsed > shadow_cfg.click_us) begin
          btn_state.running_class = EV_CLICK;
        end
      end else begin
        btn_state.running_class = EV_NONE;
      end
      btn_state.previous_level = level;
    end else if (btn_state.latched_event == it.op) begin
      // A query that finds its event pending consumes it; a miss leaves it.
      res.query_hit           = 1'b1;
      btn_state.latched_event = EV_NONE;
    end
    res.pressed       = btn_state.stable_level;
    res.pending_event = btn_state.latched_event;
    return res;
  endfunction

  function automatic item_t mk_sample(input logic level, input logic [31:0] stamp);
    item_t it;
    it.op        = OP_SAMPLE;
    it.raw_level = level;
    it.now_us    = stamp;
    return it;
  endfunction

  // Picks an elapsed time at, one short of or one over one of the configured thresholds,
  // so that the strict compares are hit exactly, or else a random time up to that threshold.
  function automatic logic [31:0] near_threshold();
    logic [31:0] limit;
    case ($urandom_range(3))
      0: begin
        limit = shadow_cfg.debounce_us;
      end
      1: begin
        limit = shadow_cfg.click_us;
      end
      2: begin
        limit = shadow_cfg.hold_us;
      end
      default: begin
        limit = shadow_cfg.long_press_us;
      end
    endcase
    case ($urandom_range(3))
      0: begin
        return limit - 32'd1;
      end
      1: begin
        return limit;
      end
      2: begin
        return limit + 32'd1;
      end
      default: begin
        return $urandom_range(limit);
      end
    endcase
  endfunction

  // One APB write: setup cycle, then access cycle. The bus is left selected
  // so that back-to-back writes never drive psel low and high in one step;
  // bus_release() parks it after a series.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    case (idx)
      REG_INVERT_LEVEL: begin
        shadow_cfg.invert_level = value[0];
      end
      REG_DEBOUNCE_US: begin
        shadow_cfg.debounce_us = value;
      end
      REG_CLICK_US: begin
        shadow_cfg.click_us = value;
      end
      REG_HOLD_US: begin
        shadow_cfg.hold_us = value;
      end
      REG_LONG_PRESS_US: begin
        shadow_cfg.long_press_us = value;
      end
      default: begin
      end
    endcase
  endtask

  task automatic bus_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_config(input logic inv, input logic [31:0] deb, input logic [31:0] clk_th,
                             input logic [31:0] hold_th, input logic [31:0] long_th);
    apb_write(REG_INVERT_LEVEL, {31'd0, inv});
    apb_write(REG_DEBOUNCE_US, deb);
    apb_write(REG_CLICK_US, clk_th);
    apb_write(REG_HOLD_US, hold_th);
    apb_write(REG_LONG_PRESS_US, long_th);
  endtask

  // Offers one item and returns at the edge where its transfer happens.
  // Valid stays high afterwards, so a following item goes out back to back;
  // whoever ends a burst lowers it.
  task automatic send_item(input item_t it, input logic typed, input result_t want);
    result_t predicted;
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item_data  <= it;
    do begin
      @(posedge clk);
    end while (!item_ready);
    // The predictor always runs so its state tracks the block; a typed row
    // supplies its own expectation instead of the predicted one.
    predicted = debounce_step(it);
    due_results.push_back(typed ? want : predicted);
  endtask

  // Waits until every owed result has arrived, then idles before returning.
  task automatic drain();
    while (due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random traffic shaped as button activity: each episode flips the level,
  // bounces up to three times inside the debounce window, then holds the level
  // with samples at elapsed times close to the thresholds, mostly rising.
  // Queries are sprinkled in, and about one pass in ten sends one noise item instead.
  task automatic run_presses(input int n_items);
    int          sent;
    logic        level;
    logic [31:0] stamp;
    logic [31:0] base;
    logic [31:0] elapsed;
    logic [31:0] pick;
    item_t       it;
    sent  = 0;
    level = 1'($urandom_range(1));
    stamp = $urandom;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        it.op        = 2'($urandom_range(OP_QUERY_LONG, OP_SAMPLE));
        it.raw_level = 1'($urandom_range(1));
        it.now_us    = $urandom;
        send_item(it, CHECK_MODEL, '0);
        sent++;
      end else begin
        level = !level;
        stamp = stamp + $urandom_range(shadow_cfg.debounce_us);
        send_item(mk_sample(level, stamp), CHECK_MODEL, '0);
        sent++;
        repeat ($urandom_range(3)) begin
          stamp = stamp + $urandom_range(shadow_cfg.debounce_us);
          send_item(mk_sample(!level, stamp), CHECK_MODEL, '0);
          stamp = stamp + $urandom_range(shadow_cfg.debounce_us);
          send_item(mk_sample(level, stamp), CHECK_MODEL, '0);
          sent += 2;
        end
        base    = stamp;
        elapsed = '0;
        repeat ($urandom_range(5, 1)) begin
          pick = near_threshold();
          if ($urandom_range(4) != 0 && pick < elapsed) begin
            pick = elapsed;
          end
          elapsed = pick;
          stamp   = base + elapsed;
          send_item(mk_sample(level, stamp), CHECK_MODEL, '0);
          sent++;
          if ($urandom_range(9) < 3) begin
            it.op        = 2'($urandom_range(OP_QUERY_LONG, OP_QUERY_CLICK));
            it.raw_level = 1'($urandom_range(1));
            it.now_us    = $urandom;
            send_item(it, CHECK_MODEL, '0);
            sent++;
          end
        end
      end
    end
  endtask

  // Result receiver. It stalls at random while gaps are on, and on request
  // holds off for a long stretch so the block fills and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        result_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Result checker: each transfer is compared with the oldest owed result.
  initial begin : result_check
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result transfer: %p", result_data);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (result_data.pressed !== want.pressed) begin
            $error("pressed: expected %0d, got %0d", want.pressed, result_data.pressed);
            mismatch_count++;
          end
          if (result_data.pending_event !== want.pending_event) begin
            $error("pending_event: expected %0d, got %0d",
                   want.pending_event, result_data.pending_event);
            mismatch_count++;
          end
          if (result_data.query_hit !== want.query_hit) begin
            $error("query_hit: expected %0d, got %0d", want.query_hit, result_data.query_hit);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_button_debounce_press_classifier: done, errors");
    $finish;
  end

  // Main sequence: reset, directed rows, then phases of random traffic,
  // each under its own register setting, any new one written while the block is idle.
  initial begin
    shadow_cfg.invert_level  = 1'b0;
    shadow_cfg.debounce_us   = DEBOUNCE_US_RST;
    shadow_cfg.click_us      = CLICK_US_RST;
    shadow_cfg.hold_us       = HOLD_US_RST;
    shadow_cfg.long_press_us = LONG_PRESS_US_RST;
    btn_state                = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
    end
    item_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          // Reset setting, kept as it came out of reset.
        end
        1: begin
          // Lowest extremes: inverted pin, every timer at zero.
          load_config(1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
        end
        2: begin
          // Highest extremes: the debounced state can never move.
          load_config(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        end
        3: begin
          // Small random thresholds in any order, and a long receiver stall.
          load_config(1'($urandom_range(1)), $urandom_range(400, 1), $urandom_range(3000),
                      $urandom_range(6000), $urandom_range(9000));
          hold_off_req = 1'b1;
        end
        4: begin
          // Ordered thresholds, spare register writes, and no idling at all.
          load_config(1'b1, 32'd20, 32'd100, 32'd400, 32'd900);
          for (logic [3:0] idx = {1'b0, REG_SPARE_LO}; idx <= {1'b0, REG_SPARE_HI}; idx++) begin
            apb_write(idx[2:0], $urandom);
          end
          gaps_on = 1'b0;
        end
        default: begin
          load_config(1'($urandom_range(1)), $urandom_range(200), $urandom_range(1000, 300),
                      $urandom_range(3000, 1001), $urandom_range(6000, 3001));
        end
      endcase
      bus_release();
      run_presses(ITEMS_PER_PHASE);
      item_valid <= 1'b0;
      gaps_on = 1'b1;
    end

    drain();
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("tb_button_debounce_press_classifier: done, clean");
    end else begin
      $display("tb_button_debounce_press_classifier: done, errors");
    end
    $finish;
  end

endmodule
